// ===== sv/damped_wave_grid_stepper_unit_macros.svh =====
// assertion helpers
`ifndef DAMPED_WAVE_GRID_STEPPER_UNIT_MACROS_SVH
`define DAMPED_WAVE_GRID_STEPPER_UNIT_MACROS_SVH

`define DWGS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define DWGS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/dwgs_pkg.sv =====
package dwgs_pkg;

  localparam int MaxRows    = 128;
  localparam int MaxCols    = 128;
  localparam int HeightBits = 16;
  localparam int RowBits    = $clog2(MaxRows);
  localparam int ColBits    = $clog2(MaxCols);
  localparam int Cells      = MaxRows * MaxCols;
  localparam int AddrBits   = $clog2(Cells);
  localparam int CoefBits   = 20;
  localparam int AccBits    = 24;
  localparam int PaddrBits  = 5;

  localparam logic [1:0] CmdTick    = 2'd0;
  localparam logic [1:0] CmdDisturb = 2'd1;
  localparam logic [1:0] CmdRead    = 2'd2;

  localparam logic [2:0] RegCoefPrev = 3'd0;
  localparam logic [2:0] RegCoefCurr = 3'd1;
  localparam logic [2:0] RegCoefNbr  = 3'd2;
  localparam logic [2:0] RegStepTime = 3'd3;
  localparam logic [2:0] RegRows     = 3'd4;
  localparam logic [2:0] RegCols     = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        elapsed;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [15:0] magnitude;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic               stepped;
    logic               status;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StClear, StRdWait, StRdDone, StDistRd, StDistWr,
    StStepRd, StStepMac, StStepWr, StOut
  } state_e;

  function automatic logic signed [HeightBits-1:0] sat_h(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd32767;
    lo = -48'sd32768;
    if (v > hi) return 16'sh7fff;
    else if (v < lo) return 16'sh8000;
    else return v[HeightBits-1:0];
  endfunction

endpackage

// ===== sv/dwgs_ram.sv =====
module dwgs_ram #(
  parameter int Width = 16,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/dwgs_core.sv =====
`include "damped_wave_grid_stepper_unit_macros.svh"
module dwgs_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dwgs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dwgs_pkg::out_item_t out_data_o,
  input  logic signed [19:0]  k1_i,
  input  logic signed [19:0]  k2_i,
  input  logic signed [19:0]  k3_i,
  input  logic [15:0]         step_time_i,
  input  logic [7:0]          rows_i,
  input  logic [7:0]          cols_i
);
  localparam int AW = dwgs_pkg::AddrBits;

  dwgs_pkg::state_e state_q, state_d;
  dwgs_pkg::in_item_t item_q, item_d;
  dwgs_pkg::out_item_t res_q, res_d;
  logic cur_b_q, cur_b_d;
  logic [dwgs_pkg::AccBits-1:0] acc_q, acc_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [7:0] ri_q, ri_d, ci_q, ci_d;
  logic [2:0] ph_q, ph_d;
  logic signed [15:0] c_q, c_d, p_q, p_d;
  logic signed [17:0] ns_q, ns_d;
  logic signed [37:0] m1_q, m2_q, m3_q;
  logic signed [37:0] m1_d, m2_d, m3_d;

  logic we_a, we_b;
  logic [AW-1:0] ra_a, ra_b, wa;
  logic [15:0] wd, rd_a, rd_b;

  dwgs_ram #(.Width(16), .Depth(dwgs_pkg::Cells)) u_grid_a (
    .clk_i, .we_i(we_a), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra_a), .rdata_o(rd_a));
  dwgs_ram #(.Width(16), .Depth(dwgs_pkg::Cells)) u_grid_b (
    .clk_i, .we_i(we_b), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra_b), .rdata_o(rd_b));

  logic [7:0] rows, cols;
  assign rows = (rows_i > 8'd128) ? 8'd128 : rows_i;
  assign cols = (cols_i > 8'd128) ? 8'd128 : cols_i;

  logic signed [15:0] cur_rd, prv_rd;
  assign cur_rd = cur_b_q ? rd_b : rd_a;
  assign prv_rd = cur_b_q ? rd_a : rd_b;

  function automatic logic [AW-1:0] idx(input logic [7:0] r, input logic [7:0] c,
                                        input logic [7:0] nc);
    logic [15:0] p;
    p = r * nc + {8'd0, c};
    return p[AW-1:0];
  endfunction

  logic [24:0] tsum;
  assign tsum = {1'b0, acc_q} + {9'd0, item_q.elapsed};

  logic cur_wr, prv_wr;
  logic [AW-1:0] rd_addr;
  logic [7:0] rr, cc;
  logic signed [47:0] tot;
  logic signed [16:0] half;
  logic signed [16:0] addv;
  assign half = {item_q.magnitude[15], item_q.magnitude >>> 1};

  assign in_ready_o = (state_q == dwgs_pkg::StIdle);
  assign out_valid_o = (state_q == dwgs_pkg::StOut);
  assign out_data_o = res_q;

  always_comb begin
    state_d = state_q; item_d = item_q; res_d = res_q; cur_b_d = cur_b_q;
    acc_d = acc_q; clr_d = clr_q; ri_d = ri_q; ci_d = ci_q; ph_d = ph_q;
    c_d = c_q; p_d = p_q; ns_d = ns_q;
    m1_d = m1_q; m2_d = m2_q; m3_d = m3_q;
    cur_wr = 1'b0; prv_wr = 1'b0; wd = '0; wa = '0; rd_addr = '0;
    rr = ri_q; cc = ci_q; tot = '0; addv = '0;
    case (state_q)
      dwgs_pkg::StClear: begin
        wa = clr_q; cur_wr = 1'b1; prv_wr = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == {AW{1'b1}}) state_d = dwgs_pkg::StIdle;
      end
      dwgs_pkg::StIdle: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d = '0;
          state_d = dwgs_pkg::StOut;
          case (in_data_i.cmd)
            dwgs_pkg::CmdTick: begin
              state_d = dwgs_pkg::StRdWait;
            end
            dwgs_pkg::CmdDisturb: begin
              if ({1'b0, in_data_i.row} > 8'd1 && {1'b0, in_data_i.row} + 8'd2 < rows &&
                  {1'b0, in_data_i.col} > 8'd1 && {1'b0, in_data_i.col} + 8'd2 < cols) begin
                ph_d = '0; state_d = dwgs_pkg::StDistRd;
              end else res_d.status = 1'b1;
            end
            dwgs_pkg::CmdRead: begin
              if ({1'b0, in_data_i.row} < rows && {1'b0, in_data_i.col} < cols) begin
                rd_addr = idx({1'b0, in_data_i.row}, {1'b0, in_data_i.col}, cols);
                state_d = dwgs_pkg::StRdDone;
              end else res_d.status = 1'b1;
            end
            default: res_d.status = 1'b1;
          endcase
        end
      end
      dwgs_pkg::StRdDone: begin
        res_d.height = cur_rd; state_d = dwgs_pkg::StOut;
      end
      dwgs_pkg::StRdWait: begin
        // tick: accumulate, maybe start the sweep
        acc_d = tsum[24] ? {dwgs_pkg::AccBits{1'b1}} : tsum[23:0];
        if ((tsum[24] ? {dwgs_pkg::AccBits{1'b1}} : tsum[23:0]) >= {8'd0, step_time_i}) begin
          res_d.stepped = 1'b1;
          if (rows < 8'd3 || cols < 8'd3) begin
            cur_b_d = ~cur_b_q; acc_d = '0; state_d = dwgs_pkg::StOut;
          end else begin
            ri_d = 8'd1; ci_d = 8'd1; ph_d = '0; state_d = dwgs_pkg::StStepRd;
          end
        end else state_d = dwgs_pkg::StOut;
      end
      dwgs_pkg::StDistRd: begin
        // read one of five cells: centre, right, left, below, above
        rr = {1'b0, item_q.row}; cc = {1'b0, item_q.col};
        case (ph_q)
          3'd1: cc = cc + 8'd1;
          3'd2: cc = cc - 8'd1;
          3'd3: rr = rr + 8'd1;
          3'd4: rr = rr - 8'd1;
          default: ;
        endcase
        rd_addr = idx(rr, cc, cols);
        state_d = dwgs_pkg::StDistWr;
      end
      dwgs_pkg::StDistWr: begin
        rr = {1'b0, item_q.row}; cc = {1'b0, item_q.col};
        case (ph_q)
          3'd1: cc = cc + 8'd1;
          3'd2: cc = cc - 8'd1;
          3'd3: rr = rr + 8'd1;
          3'd4: rr = rr - 8'd1;
          default: ;
        endcase
        addv = (ph_q == 3'd0) ? {item_q.magnitude[15], item_q.magnitude} : half;
        wa = idx(rr, cc, cols);
        wd = dwgs_pkg::sat_h(48'(cur_rd) + 48'(addv));
        cur_wr = 1'b1;
        ph_d = ph_q + 3'd1;
        state_d = (ph_q == 3'd4) ? dwgs_pkg::StOut : dwgs_pkg::StDistRd;
      end
      dwgs_pkg::StStepRd: begin
        // phases 0..5 issue reads: prev and curr, curr, right, left, below, above
        // data of phase n arrives at phase n+1
        rr = ri_q; cc = ci_q;
        case (ph_q)
          3'd2: cc = ci_q + 8'd1;
          3'd3: cc = ci_q - 8'd1;
          3'd4: rr = ri_q + 8'd1;
          3'd5: rr = ri_q - 8'd1;
          default: ;
        endcase
        rd_addr = idx(rr, cc, cols);
        case (ph_q)
          3'd1: p_d = prv_rd;
          3'd2: c_d = cur_rd;
          3'd3: ns_d = 18'(cur_rd);
          3'd4, 3'd5: ns_d = ns_q + 18'(cur_rd);
          default: ;
        endcase
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd5) state_d = dwgs_pkg::StStepMac;
      end
      dwgs_pkg::StStepMac: begin
        ns_d = ns_q + 18'(cur_rd);
        m1_d = 38'(k1_i * p_q);
        m2_d = 38'(k2_i * c_q);
        m3_d = 38'(k3_i * (ns_q + 18'(cur_rd)));
        state_d = dwgs_pkg::StStepWr;
      end
      dwgs_pkg::StStepWr: begin
        tot = 48'(m1_q) + 48'(m2_q) + 48'(m3_q) + 48'sd32768;
        wa = idx(ri_q, ci_q, cols);
        wd = dwgs_pkg::sat_h(tot >>> 16);
        prv_wr = 1'b1;
        ph_d = '0;
        state_d = dwgs_pkg::StStepRd;
        if (ci_q + 8'd2 >= cols) begin
          ci_d = 8'd1;
          ri_d = ri_q + 8'd1;
          if (ri_q + 8'd2 >= rows) begin
            cur_b_d = ~cur_b_q; acc_d = '0; state_d = dwgs_pkg::StOut;
          end
        end else ci_d = ci_q + 8'd1;
      end
      dwgs_pkg::StOut: begin
        if (out_ready_i) state_d = dwgs_pkg::StIdle;
      end
      default: state_d = dwgs_pkg::StIdle;
    endcase
  end

  assign we_a = cur_b_q ? prv_wr : cur_wr;
  assign we_b = cur_b_q ? cur_wr : prv_wr;
  assign ra_a = rd_addr;
  assign ra_b = rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dwgs_pkg::StClear;
      cur_b_q <= 1'b0;
      acc_q <= '0;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      cur_b_q <= cur_b_d;
      acc_q <= acc_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; res_q <= res_d; ri_q <= ri_d; ci_q <= ci_d; ph_q <= ph_d;
    c_q <= c_d; p_q <= p_d; ns_q <= ns_d; m1_q <= m1_d; m2_q <= m2_d; m3_q <= m3_d;
  end

  `DWGS_ASSERT(a_we_excl, clk_i, rst_ni,
    !(state_q != dwgs_pkg::StClear && we_a && we_b), "both grids written")
  `DWGS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(res_q), "result dropped")
  `DWGS_ASSERT(a_stat_height, clk_i, rst_ni,
    !(out_valid_o && res_q.status && res_q.height != 16'sd0), "rejected with height")
endmodule

// ===== sv/damped_wave_grid_stepper_unit.sv =====
// a tick that reaches the step time sweeps the interior cells with six reads per cell
// (one ram read port per grid, shared address)
// one item at a time; a result waits in an output register until transferred
// reset: registers to defaults, then a clearing pass over all 16384 cells writes
// zero into both grids while no item is accepted
module damped_wave_grid_stepper_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  dwgs_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dwgs_pkg::out_item_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dwgs_pkg::PaddrBits-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  logic signed [19:0] k1_q, k2_q, k3_q;
  logic [15:0] st_q;
  logic [7:0] rows_q, cols_q;
  logic [2:0] ra;
  assign ra = paddr[dwgs_pkg::PaddrBits-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q <= '0; k2_q <= '0; k3_q <= '0; st_q <= 16'd1;
      rows_q <= 8'd128; cols_q <= 8'd128;
    end else if (psel && penable && pwrite) begin
      case (ra)
        dwgs_pkg::RegCoefPrev: k1_q <= pwdata[19:0];
        dwgs_pkg::RegCoefCurr: k2_q <= pwdata[19:0];
        dwgs_pkg::RegCoefNbr:  k3_q <= pwdata[19:0];
        dwgs_pkg::RegStepTime: st_q <= pwdata[15:0];
        dwgs_pkg::RegRows:     rows_q <= pwdata[7:0];
        dwgs_pkg::RegCols:     cols_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ra)
      dwgs_pkg::RegCoefPrev: prdata = {{12{k1_q[19]}}, k1_q};
      dwgs_pkg::RegCoefCurr: prdata = {{12{k2_q[19]}}, k2_q};
      dwgs_pkg::RegCoefNbr:  prdata = {{12{k3_q[19]}}, k3_q};
      dwgs_pkg::RegStepTime: prdata = {16'd0, st_q};
      dwgs_pkg::RegRows:     prdata = {24'd0, rows_q};
      dwgs_pkg::RegCols:     prdata = {24'd0, cols_q};
      default:               prdata = '0;
    endcase
  end

  dwgs_core u_core (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .k1_i(k1_q), .k2_i(k2_q), .k3_i(k3_q), .step_time_i(st_q),
    .rows_i(rows_q), .cols_i(cols_q)
  );
endmodule
